// ===== src/spike_word_histogram_assert.svh =====
// ----------------------------------------------------------------------------
// Spike word histogram assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SPIKE_WORD_HISTOGRAM_ASSERT_SVH
`define SPIKE_WORD_HISTOGRAM_ASSERT_SVH

// same-cycle implication
`define SWH_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define SWH_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== src/swh_pkg.sv =====
// ----------------------------------------------------------------------------
// Spike word histogram package
// Shared widths, register indexes, request kinds and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package swh_pkg;

	// parameter defaults
	localparam int MAX_WORD_BITS_DEF = 10;
	localparam int COUNT_BITS_DEF    = 32;

	// fixed field widths
	localparam int SAMPLE_W  = 16;
	localparam int INDEX_W   = 10;
	localparam int WLEN_W    = 4;
	localparam int BLEN_W    = 10;
	localparam int EFF_W     = 5;
	localparam int SHIFT_W   = 10;
	localparam int WIDE_W    = 17;
	localparam int OUT_CNT_W = 32;
	localparam int CNT_EXT_W = 64;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 16;
	localparam int S_DATA_W  = 32;
	localparam int M_DATA_W  = 48;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_UP_THR   = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_DOWN_THR = 4'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_WORD_LEN = 4'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_LEN  = 4'd3;

	// request kinds carried in s_axis_tuser
	localparam logic REQ_SAMPLE = 1'b0;
	localparam logic REQ_READ   = 1'b1;

	// register reset values
	localparam logic [WLEN_W-1:0] WORD_LEN_RST = 4'd4;
	localparam logic [BLEN_W-1:0] BIN_LEN_RST  = 10'd20;

endpackage

`default_nettype wire

// ===== src/swh_hist_mem.sv =====
// ----------------------------------------------------------------------------
// Spike word histogram count memory
// One write port, one registered read port, clearing sweep after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module swh_hist_mem #(
	parameter int ADDR_W = 10,
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_en,
	input  wire logic [ADDR_W-1:0] wr_addr,
	input  wire logic [DATA_W-1:0] wr_data,
	input  wire logic              rd_en,
	input  wire logic [ADDR_W-1:0] rd_addr,
	output logic      [DATA_W-1:0] rd_data,
	output logic                   clr_busy
);

	localparam int DEPTH = 1 << ADDR_W;

	logic [DATA_W-1:0] mem [DEPTH];
	logic [ADDR_W-1:0] clr_addr_q;
	logic              clr_busy_q;

	// clearing sweep, one entry a cycle from reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			clr_busy_q <= 1'b1;
		end else if (clr_busy_q) begin
			clr_addr_q <= clr_addr_q + 1'b1;
			if (clr_addr_q == {ADDR_W{1'b1}}) begin
				clr_busy_q <= 1'b0;
			end
		end
	end

	// write port, sweep has priority
	always_ff @(posedge clk) begin
		if (clr_busy_q) begin
			mem[clr_addr_q] <= '0;
		end else if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// registered read, held while the reader stalls
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

	assign clr_busy = clr_busy_q;

endmodule

`default_nettype wire

// ===== src/spike_word_histogram.sv =====
// Spike word histogram. On s_axis, a voltage sample (tuser 0) runs hysteresis
// spike detection and time binning, and each closed bin shifts its spike bit
// into the spike word and bumps that word's count in the histogram
// (saturating); a read request (tuser 1) returns one bin's count. Sustained
// rate is one beat per clock while m_axis_tready stays high; a beat passes the
// input register, the histogram read and the result register. The count
// update is a read-modify-write on a single-write-port memory, with the new
// count forwarded to a following beat that hits the same word. After reset the
// histogram is swept to zero, one entry per cycle, over all 2**MAX_WORD_BITS
// entries (1024 by default); s_axis_tready stays low until the sweep ends,
// while configuration writes are taken throughout. Configuration may only be
// written while the block is idle.
// ----------------------------------------------------------------------------
// Spike word histogram top level
// Spike onset detection, time binning, spike word histogram with readback.
// ----------------------------------------------------------------------------
`default_nettype none

module spike_word_histogram #(
	parameter int MAX_WORD_BITS = swh_pkg::MAX_WORD_BITS_DEF,
	parameter int COUNT_BITS    = swh_pkg::COUNT_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	// configuration write channel
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [swh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [swh_pkg::CFG_DAT_W-1:0]   cfg_data,
	// request stream
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  wire logic [swh_pkg::S_DATA_W-1:0]    s_axis_tdata,  // sample[15:0], bin_index[25:16]
	input  wire logic [0:0]                      s_axis_tuser,  // req_type[0]
	// result stream
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	output logic      [swh_pkg::M_DATA_W-1:0]    m_axis_tdata,  // word_value[9:0],
	                                                            // count_value[41:10],
	                                                            // spike_onset[42]
	output logic      [0:0]                      m_axis_tuser   // word_done[0]
);

	import swh_pkg::*;

	`include "spike_word_histogram_assert.svh"

	localparam int AW = MAX_WORD_BITS;

	// configuration registers
	sample_t             up_thr_q;
	sample_t             down_thr_q;
	logic [WLEN_W-1:0]   word_len_q;
	logic [BLEN_W-1:0]   bin_len_q;

	// detector and binning state
	logic                spiking_q;
	logic                spike_in_bin_q;
	logic [BLEN_W-1:0]   sample_cnt_q;
	logic [SHIFT_W-1:0]  word_shift_q;

	// stage 1: input register
	logic                v_s1;
	logic                read_s1;
	sample_t             sample_s1;
	logic [INDEX_W-1:0]  index_s1;

	// stage 2: histogram read
	logic                v_s2;
	logic                read_s2;
	logic                done_s2;
	logic                rd_ok_s2;
	logic                onset_s2;
	logic [SHIFT_W-1:0]  word_s2;
	logic [AW-1:0]       addr_s2;
	logic                fwd_s2;
	logic [COUNT_BITS-1:0] fwd_data_s2;

	// result register
	logic                out_valid_q;
	logic                out_done_q;
	logic [SHIFT_W-1:0]  out_word_q;
	logic [OUT_CNT_W-1:0] out_cnt_q;
	logic                out_onset_q;

	// stage control
	logic                en_out;
	logic                en_s2;
	logic                en_s1;
	logic                adv_s1;
	logic                clr_busy;

	// stage 1 logic
	logic                above;
	logic                below;
	logic                onset;
	logic [BLEN_W-1:0]   cnt_inc;
	logic                bin_close;
	logic [EFF_W-1:0]    eff_len;
	logic [WIDE_W-1:0]   word_mask;
	logic [WIDE_W-1:0]   word_new;
	logic [WIDE_W-1:0]   index_ext;
	logic                idx_ok;
	logic [AW-1:0]       rd_addr;
	logic                rd_en;
	logic                fwd_hit;

	// stage 2 logic
	logic [COUNT_BITS-1:0] rd_data;
	logic [COUNT_BITS-1:0] cnt_old;
	logic [COUNT_BITS-1:0] cnt_new;
	logic [COUNT_BITS-1:0] cnt_res;
	logic [CNT_EXT_W-1:0]  cnt_ext;
	logic                  wr_en;

	// handshake and stage enables
	assign en_out        = !out_valid_q || m_axis_tready;
	assign en_s2         = !v_s2 || en_out;
	assign en_s1         = !v_s1 || en_s2;
	assign s_axis_tready = en_s1 && !clr_busy;
	assign adv_s1        = v_s1 && en_s2;
	assign cfg_ready     = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_thr_q   <= '0;
			down_thr_q <= '0;
			word_len_q <= WORD_LEN_RST;
			bin_len_q  <= BIN_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_UP_THR:   up_thr_q   <= sample_t'(cfg_data);
				CFG_DOWN_THR: down_thr_q <= sample_t'(cfg_data);
				CFG_WORD_LEN: word_len_q <= cfg_data[WLEN_W-1:0];
				CFG_BIN_LEN:  bin_len_q  <= cfg_data[BLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en_s1) begin
			v_s1 <= s_axis_tvalid && s_axis_tready;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1) begin
			read_s1   <= s_axis_tuser[0];
			sample_s1 <= sample_t'(s_axis_tdata[SAMPLE_W-1:0]);
			index_s1  <= s_axis_tdata[SAMPLE_W +: INDEX_W];
		end
	end

	// onset detection with hysteresis
	assign above = sample_s1 > up_thr_q;
	assign below = sample_s1 < down_thr_q;
	assign onset = (read_s1 == REQ_SAMPLE) && above && !spiking_q;

	// bin counter and spike word
	assign cnt_inc   = sample_cnt_q + 1'b1;
	assign bin_close = (read_s1 == REQ_SAMPLE) && (cnt_inc == bin_len_q);
	always_comb begin
		if (word_len_q == '0) begin
			eff_len = EFF_W'(1);
		end else if (EFF_W'(word_len_q) > EFF_W'(MAX_WORD_BITS)) begin
			eff_len = EFF_W'(MAX_WORD_BITS);
		end else begin
			eff_len = EFF_W'(word_len_q);
		end
	end
	assign word_mask = (WIDE_W'(1) << eff_len) - WIDE_W'(1);
	assign word_new  = {{(WIDE_W-SHIFT_W-1){1'b0}}, word_shift_q, spike_in_bin_q} & word_mask;

	// histogram address, read index checked against table depth
	assign index_ext = {{(WIDE_W-INDEX_W){1'b0}}, index_s1};
	assign idx_ok    = index_ext < (WIDE_W'(1) << MAX_WORD_BITS);
	assign rd_addr   = (read_s1 == REQ_READ) ? index_ext[AW-1:0] : word_new[AW-1:0];
	assign rd_en     = adv_s1 && ((read_s1 == REQ_READ) ? idx_ok : bin_close);
	assign fwd_hit   = wr_en && (addr_s2 == rd_addr);

	// detector and binning state update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spiking_q      <= 1'b0;
			spike_in_bin_q <= 1'b0;
			sample_cnt_q   <= '0;
			word_shift_q   <= '0;
		end else if (adv_s1 && (read_s1 == REQ_SAMPLE)) begin
			sample_cnt_q   <= bin_close ? '0 : cnt_inc;
			spike_in_bin_q <= (spike_in_bin_q && !bin_close) || onset;
			if (bin_close) begin
				word_shift_q <= word_new[SHIFT_W-1:0];
			end
			if (above) begin
				spiking_q <= 1'b1;
			end else if (below) begin
				spiking_q <= 1'b0;
			end
		end
	end

	// stage 2 registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			read_s2     <= read_s1;
			done_s2     <= bin_close;
			rd_ok_s2    <= idx_ok;
			onset_s2    <= onset;
			word_s2     <= word_new[SHIFT_W-1:0];
			addr_s2     <= rd_addr;
			fwd_s2      <= fwd_hit;
			fwd_data_s2 <= cnt_new;
		end
	end

	swh_hist_mem #(
		.ADDR_W (AW),
		.DATA_W (COUNT_BITS)
	) u_mem (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_addr  (addr_s2),
		.wr_data  (cnt_new),
		.rd_en    (rd_en),
		.rd_addr  (rd_addr),
		.rd_data  (rd_data),
		.clr_busy (clr_busy)
	);

	// saturating count update
	assign cnt_old = fwd_s2 ? fwd_data_s2 : rd_data;
	assign cnt_new = (cnt_old == {COUNT_BITS{1'b1}}) ? cnt_old : cnt_old + 1'b1;
	assign wr_en   = v_s2 && en_out && done_s2;

	always_comb begin
		if (read_s2 == REQ_READ) begin
			cnt_res = rd_ok_s2 ? cnt_old : '0;
		end else begin
			cnt_res = done_s2 ? cnt_new : '0;
		end
	end
	assign cnt_ext = CNT_EXT_W'(cnt_res);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en_out) begin
			out_valid_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s2) begin
			out_done_q  <= done_s2;
			out_word_q  <= done_s2 ? word_s2 : '0;
			out_cnt_q   <= cnt_ext[OUT_CNT_W-1:0];
			out_onset_q <= onset_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_done_q;
	assign m_axis_tdata  = {{(M_DATA_W-SHIFT_W-OUT_CNT_W-1){1'b0}},
	                        out_onset_q, out_cnt_q, out_word_q};

	// checks
	`SWH_ASSERT_IMP(a_no_item_in_sweep, clr_busy, !v_s1 && !v_s2,
		"request in flight during histogram clearing sweep")
	`SWH_ASSERT_NXT(a_close_clears_cnt, adv_s1 && bin_close, sample_cnt_q == '0,
		"sample counter not cleared after bin close")
	`SWH_ASSERT_IMP(a_update_nonzero, v_s2 && done_s2, cnt_new != '0,
		"updated word count is zero")
	`SWH_ASSERT_IMP(a_read_no_event, v_s2 && (read_s2 == REQ_READ), !done_s2 && !onset_s2,
		"read request carries a bin close or onset")

endmodule

`default_nettype wire

// ===== sim/swh_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike word histogram checker
// Watches the configuration, request and result channels, keeps its own copy
// of the detector, binning and histogram state, and compares every result
// beat field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------

module swh_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic                            cfg_ready,
	input  logic [swh_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [swh_pkg::CFG_DAT_W-1:0]   cfg_data,
	input  logic                            s_axis_tvalid,
	input  logic                            s_axis_tready,
	input  logic [swh_pkg::S_DATA_W-1:0]    s_axis_tdata,
	input  logic [0:0]                      s_axis_tuser,
	input  logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	input  logic [swh_pkg::M_DATA_W-1:0]    m_axis_tdata,
	input  logic [0:0]                      m_axis_tuser,
	output int                              mismatches,
	output int                              outstanding,
	output int                              results_seen
);
	import swh_pkg::*;

	localparam int HIST_DEPTH = 1 << MAX_WORD_BITS_DEF;
	localparam logic [OUT_CNT_W-1:0] COUNT_CEIL = '1;
	localparam int PRINT_CAP = 200;

	typedef struct packed {
		logic                 done;
		logic [INDEX_W-1:0]   word;
		logic [OUT_CNT_W-1:0] count;
		logic                 onset;
	} word_result_t;

	// register copies
	sample_t           up_thr;
	sample_t           down_thr;
	logic [WLEN_W-1:0] word_len;
	logic [BLEN_W-1:0] bin_len;

	// detector, binning and histogram state
	logic                 spiking;
	logic                 spike_in_bin;
	logic [BLEN_W-1:0]    bin_fill;
	logic [SHIFT_W-1:0]   word_reg;
	logic [OUT_CNT_W-1:0] word_counts [HIST_DEPTH];

	word_result_t word_results_due [$];
	word_result_t want;
	word_result_t got;

	// one sample: advance the bin, close it if full, then run the hysteresis
	function automatic word_result_t bin_and_detect(sample_t v);
		word_result_t r;
		int eff_len;
		logic [SHIFT_W-1:0] word;
		r = '0;
		bin_fill = bin_fill + 1'b1;
		if (bin_fill == bin_len) begin
			eff_len = (word_len == 0) ? 1 :
				(word_len > MAX_WORD_BITS_DEF) ? MAX_WORD_BITS_DEF : int'(word_len);
			word = {word_reg[SHIFT_W-2:0], spike_in_bin} & SHIFT_W'((1 << eff_len) - 1);
			word_reg = word;
			if (word_counts[word] != COUNT_CEIL)
				word_counts[word] = word_counts[word] + 1'b1;
			r.done  = 1'b1;
			r.word  = word;
			r.count = word_counts[word];
			bin_fill = '0;
			spike_in_bin = 1'b0;
		end
		if (v > up_thr) begin
			if (!spiking)
				r.onset = 1'b1;
			spiking = 1'b1;
		end else if (v < down_thr) begin
			spiking = 1'b0;
		end
		if (r.onset)
			spike_in_bin = 1'b1;
		return r;
	endfunction

	task automatic report_mismatch(string what, longint unsigned exp_v, longint unsigned got_v);
		mismatches++;
		if (mismatches <= PRINT_CAP)
			$display("[%0t] mismatch %s: expected 0x%0h, got 0x%0h", $time, what, exp_v, got_v);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			up_thr       = '0;
			down_thr     = '0;
			word_len     = WORD_LEN_RST;
			bin_len      = BIN_LEN_RST;
			spiking      = 1'b0;
			spike_in_bin = 1'b0;
			bin_fill     = '0;
			word_reg     = '0;
			for (int i = 0; i < HIST_DEPTH; i++)
				word_counts[i] = '0;
			word_results_due.delete();
			mismatches   = 0;
			outstanding  = 0;
			results_seen = 0;
		end else begin
			// register writes
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_UP_THR:   up_thr   = sample_t'(cfg_data);
					CFG_DOWN_THR: down_thr = sample_t'(cfg_data);
					CFG_WORD_LEN: word_len = cfg_data[WLEN_W-1:0];
					CFG_BIN_LEN:  bin_len  = cfg_data[BLEN_W-1:0];
					default: ;
				endcase
			end

			// request beat: predict its result
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser[0] == REQ_READ) begin
					want = '0;
					want.count = word_counts[s_axis_tdata[SAMPLE_W +: INDEX_W]];
				end else begin
					want = bin_and_detect(sample_t'(s_axis_tdata[SAMPLE_W-1:0]));
				end
				word_results_due.push_back(want);
			end

			// result beat: compare with the oldest prediction
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.done  = m_axis_tuser[0];
				got.word  = m_axis_tdata[INDEX_W-1:0];
				got.count = m_axis_tdata[INDEX_W +: OUT_CNT_W];
				got.onset = m_axis_tdata[INDEX_W + OUT_CNT_W];
				if (word_results_due.size() == 0) begin
					report_mismatch("result with nothing outstanding", 0, got);
				end else begin
					want = word_results_due.pop_front();
					if (got.done != want.done)
						report_mismatch("word_done", want.done, got.done);
					if (got.word != want.word)
						report_mismatch("word_value", want.word, got.word);
					if (got.count != want.count)
						report_mismatch("count_value", want.count, got.count);
					if (got.onset != want.onset)
						report_mismatch("spike_onset", want.onset, got.onset);
				end
			end

			outstanding = word_results_due.size();
		end
	end

endmodule

// ===== sim/tb_spike_word_histogram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Spike word histogram testbench
// Drives samples and histogram reads through the request stream under a
// series of threshold, word length and bin length settings, with random
// gaps on both streams and one long result back-pressure stretch. The
// checker predicts and compares; this module makes stimulus and the verdict.
// ----------------------------------------------------------------------------

module tb_spike_word_histogram;
	import swh_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int HOLD_AFTER  = 700;
	localparam logic [CFG_IDX_W-1:0] CFG_IDX_TOP = '1;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_DAT_W-1:0]   cfg_data;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	logic [S_DATA_W-1:0]    s_axis_tdata;
	logic [0:0]             s_axis_tuser;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	logic [M_DATA_W-1:0]    m_axis_tdata;
	logic [0:0]             m_axis_tuser;

	int mismatches;
	int outstanding;
	int results_seen;
	int cycle_count;

	// stimulus-side view of the current setting
	int  cur_up;
	int  cur_down;
	int  cur_word_bits;
	bit  burst_mode;

	spike_word_histogram dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	swh_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.mismatches    (mismatches),
		.outstanding   (outstanding),
		.results_seen  (results_seen)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("spike_word_histogram verification failed");
		$finish;
	end

	// result side: random stretches of steady or gappy ready, one long hold
	initial begin
		int stall_left;
		int stretch_left;
		int r;
		bit steady;
		bit held;
		m_axis_tready = 1'b0;
		stall_left = 0;
		stretch_left = 0;
		steady = 1'b0;
		held = 1'b0;
		forever begin
			@(negedge clk);
			if (!held && results_seen >= HOLD_AFTER) begin
				held = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stretch_left == 0) begin
				steady = ($urandom_range(3) == 0);
				stretch_left = $urandom_range(150, 30);
			end
			stretch_left--;
			if (stall_left > 0) begin
				m_axis_tready = 1'b0;
				stall_left--;
			end else if (steady) begin
				m_axis_tready = 1'b1;
			end else begin
				r = $urandom_range(99);
				if (r < 60) begin
					m_axis_tready = 1'b1;
				end else if (r < 95) begin
					m_axis_tready = 1'b0;
					stall_left = $urandom_range(2);
				end else begin
					m_axis_tready = 1'b0;
					stall_left = $urandom_range(30, 8);
				end
			end
		end
	end

	// signed value in [lo, hi], or anywhere when the span is empty
	function automatic int span(int lo, int hi);
		if (lo > hi)
			return int'($urandom_range(65535)) - 32768;
		return int'($urandom_range(hi + 32768, lo + 32768)) - 32768;
	endfunction

	// samples aimed above, below and between the thresholds
	function automatic int pick_sample();
		int r;
		r = $urandom_range(99);
		if (r < 35)
			return span(cur_up + 1, 32767);
		if (r < 70)
			return span(-32768, cur_down - 1);
		if (r < 85)
			return span(cur_down, cur_up);
		return span(-32768, 32767);
	endfunction

	function automatic int pick_gap();
		int r;
		if (burst_mode)
			return 0;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 8);
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// one request beat; returns at the falling edge after acceptance
	task automatic send_beat(input logic kind, input int smp, input int idx);
		int gap;
		if ($urandom_range(49) == 0)
			burst_mode = !burst_mode;
		gap = pick_gap();
		if (gap > 0) begin
			s_axis_tvalid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = kind;
		s_axis_tdata  = {{(S_DATA_W - SAMPLE_W - INDEX_W){1'b0}},
			INDEX_W'(idx), SAMPLE_W'(smp)};
		do @(posedge clk); while (!s_axis_tready);
		@(negedge clk);
	endtask

	task automatic wait_idle();
		s_axis_tvalid = 1'b0;
		wait (outstanding == 0);
		@(negedge clk);
	endtask

	// new setting, then n_samples samples with reads mixed in
	task automatic run_phase(input int up, input int down, input int wlen, input int blen,
		input int n_samples, input int read_pct);
		int idx;
		wait_idle();
		write_reg(CFG_UP_THR, CFG_DAT_W'(up));
		write_reg(CFG_DOWN_THR, CFG_DAT_W'(down));
		write_reg(CFG_WORD_LEN, (CFG_DAT_W'($urandom) & ~CFG_DAT_W'(4'hF)) | CFG_DAT_W'(wlen));
		write_reg(CFG_BIN_LEN, (CFG_DAT_W'($urandom) & ~CFG_DAT_W'(10'h3FF)) | CFG_DAT_W'(blen));
		// unused register index, must be ignored
		if ($urandom_range(1))
			write_reg(CFG_IDX_W'($urandom_range(CFG_IDX_TOP, CFG_BIN_LEN + 1)),
				CFG_DAT_W'($urandom));
		cur_up   = up;
		cur_down = down;
		cur_word_bits = (wlen == 0) ? 1 : (wlen > MAX_WORD_BITS_DEF) ? MAX_WORD_BITS_DEF : wlen;
		for (int n = 0; n < n_samples; ) begin
			if (int'($urandom_range(99)) < read_pct) begin
				if ($urandom_range(1))
					idx = $urandom_range((1 << cur_word_bits) - 1);
				else
					idx = $urandom_range((1 << INDEX_W) - 1);
				send_beat(REQ_READ, $urandom, idx);
			end else begin
				send_beat(REQ_SAMPLE, pick_sample(), $urandom);
				n++;
			end
		end
	endtask

	task automatic random_phase(input int n_samples);
		int up;
		int down;
		up = span(-32768, 32767);
		down = up - int'($urandom_range(3000));
		if (down < -32768)
			down = -32768;
		run_phase(up, down, $urandom_range(15), $urandom_range(8, 1), n_samples, 15);
	endtask

	// stimulus and verdict
	initial begin
		int directed [20];
		directed = '{1, 0, -1, 32767, 32767, -32768, 0, 256, -256, 300,
			-1, 16'h5555, -21846, 2, 1, -2, 32767, -32767, 128, -128};
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_index     = '0;
		cfg_data      = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = REQ_SAMPLE;
		burst_mode    = 1'b0;
		cur_up        = 0;
		cur_down      = 0;
		cur_word_bits = WORD_LEN_RST;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset setting: reads of untouched bins, first (short) bin, readback
		send_beat(REQ_READ, 0, 0);
		foreach (directed[i])
			send_beat(REQ_SAMPLE, directed[i], $urandom);
		send_beat(REQ_READ, -1, 1);
		send_beat(REQ_READ, 0, (1 << INDEX_W) - 1);
		send_beat(REQ_READ, 0, 10'h155);
		send_beat(REQ_READ, 0, 10'h2AA);

		// threshold and length extremes, inverted thresholds
		run_phase(256, -256, 1, 1, 50, 15);
		run_phase(-32768, -32768, MAX_WORD_BITS_DEF, 3, 50, 15);
		run_phase(32767, 32767, 15, 2, 50, 15);
		run_phase(100, 200, 0, 4, 50, 15);
		random_phase(50);
		random_phase(50);
		random_phase(50);

		// longest bin left part full, then zero length: counter wraps through 1024
		run_phase(512, -512, 6, 1023, 40, 10);
		run_phase(300, -300, 5, 0, 1030, 5);

		random_phase(50);

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("spike_word_histogram verification clean");
		else
			$display("spike_word_histogram verification failed");
		$finish;
	end

endmodule
